// ----- hdl/dbrt_pkg.sv -----
package dbrt_pkg;

	// Input field widths.
	localparam int DEPTH_BITS       = 16;
	localparam int COORD_INDEX_BITS = 12;
	localparam int COLOR_W          = 8;

	// Register and result widths.
	localparam int CENTER_W  = 16;
	localparam int RECIP_W   = 24;
	localparam int POSE_W    = 64;
	localparam int COEF_W    = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 32;

	// Configuration register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_RECIP_FOCAL_X,
		REG_RECIP_FOCAL_Y,
		REG_RECIP_DEPTH_SCALE,
		REG_POSE_ROW_X,
		REG_POSE_ROW_Y,
		REG_POSE_ROW_Z
	} cfg_reg_t;

	// Reset values of the registers.
	localparam logic [CENTER_W-1:0] CENTER_X_RST          = 16'd5120;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST          = 16'd3840;
	localparam logic [RECIP_W-1:0]  RECIP_FOCAL_X_RST     = 24'd31957;
	localparam logic [RECIP_W-1:0]  RECIP_FOCAL_Y_RST     = 24'd31957;
	localparam logic [RECIP_W-1:0]  RECIP_DEPTH_SCALE_RST = 24'd16777;
	localparam logic [POSE_W-1:0]   POSE_ROW_X_RST        = 64'd16384;
	localparam logic [POSE_W-1:0]   POSE_ROW_Y_RST        = 64'd1073741824;
	localparam logic [POSE_W-1:0]   POSE_ROW_Z_RST        = 64'd70368744177664;

	// Internal datapath widths.
	localparam int IDX_SH_W = COORD_INDEX_BITS + 4;
	localparam int DIFF_W   = ((IDX_SH_W > CENTER_W) ? IDX_SH_W : CENTER_W) + 1;
	localparam int RAYP_W   = DIFF_W + RECIP_W + 1;
	localparam int RAY_W    = RAYP_W - 12;
	localparam int ZP_W     = DEPTH_BITS + RECIP_W + 1;
	localparam int ZC_W     = COORD_W - 1;
	localparam int LAT_W    = RAY_W + ZC_W;
	localparam int LATR_W   = LAT_W + 1;
	localparam int PROD_W   = COEF_W + COORD_W;
	localparam int ACC_W    = PROD_W + 3;

	typedef struct packed {
		logic [DEPTH_BITS-1:0]       depth_raw;
		logic [COORD_INDEX_BITS-1:0] pixel_col;
		logic [COORD_INDEX_BITS-1:0] pixel_row;
		logic [COLOR_W-1:0]          blue_in;
		logic [COLOR_W-1:0]          green_in;
		logic [COLOR_W-1:0]          red_in;
	} pixel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [COLOR_W-1:0]        blue_out;
		logic [COLOR_W-1:0]        green_out;
		logic [COLOR_W-1:0]        red_out;
	} point_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} color_t;

endpackage

// ----- hdl/dbrt_ifs.sv -----
interface dbrt_pixel_if import dbrt_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dbrt_point_if import dbrt_pkg::*; ();
	logic   valid;
	logic   ready;
	point_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/depth_backproject_rigid_transform.sv -----
// Channel   Direction  Handshake     Word
// pix       in         valid/ready   depth_raw, pixel_col, pixel_row, blue/green/red_in
// pnt       out        valid/ready   point_x/y/z (Q16.16), blue/green/red_out
// cfg       in         cfg_we only   cfg_index selects one of eight registers
//
// One word enters per clock while the pipeline is not stalled.
// The pipeline has seven register stages: depth and ray products,
// rounding, two lateral multipliers, lateral saturation, nine rotation
// products, row sums, and final rounding into the output register.
// A word with zero depth is dropped at the input and gives no result.
// arst_n clears all valid bits and loads the register reset values.
// Each stage holds only while it is full and the stage after it is blocked, so bubbles
// close up and the input keeps taking words while a result waits, until all are full.
module depth_backproject_rigid_transform import dbrt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	dbrt_pixel_if.sink           pix,
	dbrt_point_if.source         pnt
);

	// Configuration registers. The user must change them only while the pipeline is empty;
	// the block itself does not enforce this, and every stage reads them directly.
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [RECIP_W-1:0]  recip_fx_q;
	logic [RECIP_W-1:0]  recip_fy_q;
	logic [RECIP_W-1:0]  recip_ds_q;
	logic [POSE_W-1:0]   pose_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			recip_fx_q <= RECIP_FOCAL_X_RST;
			recip_fy_q <= RECIP_FOCAL_Y_RST;
			recip_ds_q <= RECIP_DEPTH_SCALE_RST;
			pose_q[0]  <= POSE_ROW_X_RST;
			pose_q[1]  <= POSE_ROW_Y_RST;
			pose_q[2]  <= POSE_ROW_Z_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:          center_x_q <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:          center_y_q <= cfg_data[CENTER_W-1:0];
				REG_RECIP_FOCAL_X:     recip_fx_q <= cfg_data[RECIP_W-1:0];
				REG_RECIP_FOCAL_Y:     recip_fy_q <= cfg_data[RECIP_W-1:0];
				REG_RECIP_DEPTH_SCALE: recip_ds_q <= cfg_data[RECIP_W-1:0];
				REG_POSE_ROW_X:        pose_q[0]  <= cfg_data[POSE_W-1:0];
				REG_POSE_ROW_Y:        pose_q[1]  <= cfg_data[POSE_W-1:0];
				REG_POSE_ROW_Z:        pose_q[2]  <= cfg_data[POSE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Rounds a signed ray product by 2^12, half away from zero, and returns
	// the sign followed by the magnitude.
	function automatic logic [RAY_W:0] ray_round(input logic signed [RAYP_W-1:0] p);
		logic                neg;
		logic [RAYP_W-1:0]   mag;
		logic [RAYP_W-1:0]   rnd;
		neg = p[RAYP_W-1];
		mag = neg ? RAYP_W'(-p) : RAYP_W'(p);
		rnd = (mag + RAYP_W'(2048)) >> 12;
		return {neg, rnd[RAY_W-1:0]};
	endfunction

	// Rounds a lateral magnitude by 2^16, applies the sign and saturates.
	function automatic logic [COORD_W-1:0] lat_round(input logic neg,
	                                                 input logic [LAT_W-1:0] m);
		logic [LATR_W-1:0] r;
		r = (LATR_W'(m) + LATR_W'(32768)) >> 16;
		if (neg) begin
			if (r >= LATR_W'(64'h8000_0000)) return 32'h8000_0000;
			return COORD_W'(0) - r[COORD_W-1:0];
		end
		if (r > LATR_W'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
		return r[COORD_W-1:0];
	endfunction

	// Rounds a row sum by 2^14, half away from zero, and saturates.
	function automatic logic [COORD_W-1:0] row_round(input logic signed [ACC_W-1:0] a);
		logic             neg;
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] r;
		neg = a[ACC_W-1];
		mag = neg ? ACC_W'(-a) : ACC_W'(a);
		r   = (mag + ACC_W'(8192)) >> 14;
		if (neg) begin
			if (r >= ACC_W'(64'h8000_0000)) return 32'h8000_0000;
			return COORD_W'(0) - r[COORD_W-1:0];
		end
		if (r > ACC_W'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
		return r[COORD_W-1:0];
	endfunction

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !vld_s7 || pnt.ready;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign pix.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pix.valid && (pix.data.depth_raw != '0);
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: pixel offsets from the principal point, in Q.4 pixels.
	logic signed [DIFF_W-1:0] dx_c;
	logic signed [DIFF_W-1:0] dy_c;

	assign dx_c = $signed(DIFF_W'({pix.data.pixel_col, 4'b0000})) - $signed(DIFF_W'(center_x_q));
	assign dy_c = $signed(DIFF_W'({pix.data.pixel_row, 4'b0000})) - $signed(DIFF_W'(center_y_q));

	logic [ZP_W-2:0]          zprod_s1;
	logic signed [RAYP_W-1:0] rayp_x_s1, rayp_y_s1;
	color_t                   color_s1;

	logic [ZC_W-1:0]  zc_s2;
	logic             neg_x_s2, neg_y_s2;
	logic [RAY_W-1:0] ray_x_s2, ray_y_s2;
	color_t           color_s2;

	logic [ZC_W-1:0]  zc_s3;
	logic             neg_x_s3, neg_y_s3;
	logic [LAT_W-1:0] lat_x_s3, lat_y_s3;
	color_t           color_s3;

	logic signed [COORD_W-1:0] coord_s4 [3];
	color_t                    color_s4;

	logic signed [PROD_W-1:0] prod_s5 [3][3];
	color_t                   color_s5;

	logic signed [ACC_W-1:0] acc_s6 [3];
	color_t                  color_s6;

	logic [COORD_W-1:0] coord_s7 [3];
	color_t             color_s7;

	// Stage 2 combinational: depth in Q16.16 with rounding and saturation.
	logic [ZP_W-1:0] zsum_c;
	logic [ZP_W-1:0] zsh_c;
	logic [ZC_W-1:0] zc_c;
	logic [RAY_W:0]  rx_c, ry_c;

	assign zsum_c = {1'b0, zprod_s1} + ZP_W'(128);
	assign zsh_c  = zsum_c >> 8;
	assign zc_c   = (zsh_c > ZP_W'({ZC_W{1'b1}})) ? {ZC_W{1'b1}} : zsh_c[ZC_W-1:0];
	assign rx_c   = ray_round(rayp_x_s1);
	assign ry_c   = ray_round(rayp_y_s1);

	always_ff @(posedge clk) begin
		if (en1) begin
			zprod_s1  <= (ZP_W-1)'(pix.data.depth_raw) * (ZP_W-1)'(recip_ds_q);
			rayp_x_s1 <= dx_c * $signed({1'b0, recip_fx_q});
			rayp_y_s1 <= dy_c * $signed({1'b0, recip_fy_q});
			color_s1  <= '{blue: pix.data.blue_in, green: pix.data.green_in,
			               red: pix.data.red_in};
		end
		if (en2) begin
			zc_s2    <= zc_c;
			neg_x_s2 <= rx_c[RAY_W];
			ray_x_s2 <= rx_c[RAY_W-1:0];
			neg_y_s2 <= ry_c[RAY_W];
			ray_y_s2 <= ry_c[RAY_W-1:0];
			color_s2 <= color_s1;
		end
		if (en3) begin
			zc_s3    <= zc_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			lat_x_s3 <= LAT_W'(ray_x_s2) * LAT_W'(zc_s2);
			lat_y_s3 <= LAT_W'(ray_y_s2) * LAT_W'(zc_s2);
			color_s3 <= color_s2;
		end
		if (en4) begin
			coord_s4[0] <= $signed(lat_round(neg_x_s3, lat_x_s3));
			coord_s4[1] <= $signed(lat_round(neg_y_s3, lat_y_s3));
			coord_s4[2] <= $signed({1'b0, zc_s3});
			color_s4    <= color_s3;
		end
		// Stage 5: one product per rotation entry; entry c of a row weighs
		// coordinate c (x, y, z from the low end of the packed row).
		if (en5) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s5[r][c] <= $signed(pose_q[r][COEF_W*c +: COEF_W]) * coord_s4[c];
				end
			end
			color_s5 <= color_s4;
		end
		// Stage 6: row sums with the Q8.8 translation lifted to Q.30.
		if (en6) begin
			for (int r = 0; r < 3; r++) begin
				acc_s6[r] <= ACC_W'(prod_s5[r][0]) + ACC_W'(prod_s5[r][1])
				           + ACC_W'(prod_s5[r][2])
				           + (ACC_W'($signed(pose_q[r][POSE_W-1 -: COEF_W])) <<< 22);
			end
			color_s6 <= color_s5;
		end
		if (en7) begin
			for (int r = 0; r < 3; r++) begin
				coord_s7[r] <= row_round(acc_s6[r]);
			end
			color_s7 <= color_s6;
		end
	end

	assign pnt.valid          = vld_s7;
	assign pnt.data.point_x   = $signed(coord_s7[0]);
	assign pnt.data.point_y   = $signed(coord_s7[1]);
	assign pnt.data.point_z   = $signed(coord_s7[2]);
	assign pnt.data.blue_out  = color_s7.blue;
	assign pnt.data.green_out = color_s7.green;
	assign pnt.data.red_out   = color_s7.red;

endmodule

// ----- hdl/dbrt_checker.sv -----
module dbrt_checker import dbrt_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input point_t out_data
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A result that is not taken keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// The pipeline only pushes back when the output register is blocked.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with the output free");

	// Nothing is offered in the first cycle after reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result offered right after reset");

endmodule

bind depth_backproject_rigid_transform dbrt_checker u_dbrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix.ready),
	.out_valid (pnt.valid),
	.out_ready (pnt.ready),
	.out_data  (pnt.data)
);
